// ----- rtl/cobf_pkg.sv -----
// Package for the cascaded one-pole band filter.
// Holds the widths, payload types, register indexes, unit opcodes and the saturation helper.
// No dependencies; every other file depends on it.
`default_nettype none

package cobf_pkg;

  localparam int unsigned STAGES      = 3;
  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned COEF_BITS   = 18;

  localparam int unsigned STG_W  = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam int unsigned DIFF_W = SAMPLE_BITS + 1;
  localparam int unsigned PROD_W = COEF_BITS + 1 + DIFF_W;
  localparam int unsigned RND_W  = PROD_W - COEF_BITS;
  localparam int unsigned SUM_W  = SAMPLE_BITS + 3;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = COEF_BITS;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic        [COEF_BITS-1:0]   coef_t;
  typedef logic        [CFG_ADDR_W-1:0]  cfg_addr_t;
  typedef logic        [CFG_DATA_W-1:0]  cfg_data_t;

  localparam cfg_addr_t REG_LOW_ENABLE   = CFG_ADDR_W'(0);
  localparam cfg_addr_t REG_HIGH_ENABLE  = CFG_ADDR_W'(1);
  localparam cfg_addr_t REG_SINGLE_STAGE = CFG_ADDR_W'(2);
  localparam cfg_addr_t REG_LOW_COEFF    = CFG_ADDR_W'(3);
  localparam cfg_addr_t REG_HIGH_COEFF   = CFG_ADDR_W'(4);

  localparam coef_t LOW_COEFF_RST  = COEF_BITS'(170977);
  localparam coef_t HIGH_COEFF_RST = COEF_BITS'(258435);

  typedef struct packed {
    logic  low_enable;
    logic  high_enable;
    logic  single_stage;
    coef_t low_coeff;
    coef_t high_coeff;
  } cfg_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_MUL,
    OP_ADD,
    OP_SUB
  } op_e;

  typedef struct packed {
    op_e     op;
    sample_t x;
    sample_t z;
    coef_t   coeff;
  } unit_req_t;

  function automatic sample_t sat_sum(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-SAMPLE_BITS:0] top;
    top = v[SUM_W-1:SAMPLE_BITS-1];
    if ((&top) || !(|top)) begin
      return v[SAMPLE_BITS-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/cobf_if.sv -----
// Handshake interfaces for the cascaded one-pole band filter: sample in, sample out and
// configuration write channels.
// Depends on cobf_pkg.
`default_nettype none

interface cobf_in_if;
  logic              valid;
  logic              ready;
  cobf_pkg::sample_t sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface cobf_out_if;
  logic              valid;
  logic              ready;
  cobf_pkg::sample_t sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

interface cobf_cfg_if;
  logic                valid;
  logic                ready;
  cobf_pkg::cfg_addr_t addr;
  cobf_pkg::cfg_data_t data;
  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/cascaded_one_pole_band_filter.sv -----
// Top level of the cascaded one-pole band filter.
// Depends on cobf_pkg, the interfaces, cobf_regs, cobf_unit and cobf_ctrl.
//
// Samples enter on in_i and filtered samples leave on out_o, one per transaction, in order.
// Registers are written on cfg_i, which is always ready; indexes 0 to 4 select low enable,
// high enable, single stage, low pole and high pole, and other indexes are ignored.
// Write them only while no sample is in flight.
// One arithmetic unit, with its multiplier, adders and subtractors, is shared by all stages.
// A low-pass stage steps through multiply and rounded add, and a high-pass stage through
// multiply, add and difference. Each section has three stages, or one with single stage set;
// with both sections disabled the sample passes unchanged.
// in_i is not ready while a sample is being worked on; it becomes ready again once the
// previous result is loaded into the output register, even while out_o is stalled.
// A stalled receiver holds the result in the output register and, once the next sample is
// finished, stops the block until that register is free.
// Reset clears all stage memories and restores the default registers.
`default_nettype none

module cascaded_one_pole_band_filter (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cobf_in_if.sink    in_i,
  cobf_out_if.source out_o,
  cobf_cfg_if.sink   cfg_i
);
  import cobf_pkg::*;

  cfg_t      cfg;
  unit_req_t req;
  sample_t   res;

  cobf_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  cobf_unit u_unit (
    .clk_i (clk_i),
    .req_i (req),
    .res_o (res)
  );

  cobf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .out_o  (out_o),
    .req_o  (req),
    .res_i  (res)
  );

endmodule

`default_nettype wire

// ----- rtl/cobf_regs.sv -----
// Configuration register file of the cascaded one-pole band filter.
// Depends on cobf_pkg and cobf_cfg_if.
`default_nettype none

module cobf_regs (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  cobf_cfg_if.sink       cfg_i,
  output cobf_pkg::cfg_t cfg_o
);
  import cobf_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.addr)
        REG_LOW_ENABLE:   cfg_d.low_enable   = cfg_i.data[0];
        REG_HIGH_ENABLE:  cfg_d.high_enable  = cfg_i.data[0];
        REG_SINGLE_STAGE: cfg_d.single_stage = cfg_i.data[0];
        REG_LOW_COEFF:    cfg_d.low_coeff    = cfg_i.data[COEF_BITS-1:0];
        REG_HIGH_COEFF:   cfg_d.high_coeff   = cfg_i.data[COEF_BITS-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_enable   <= 1'b1;
      cfg_q.high_enable  <= 1'b1;
      cfg_q.single_stage <= 1'b0;
      cfg_q.low_coeff    <= LOW_COEFF_RST;
      cfg_q.high_coeff   <= HIGH_COEFF_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cobf_unit.sv -----
// Shared arithmetic unit: pole multiply into a product register, rounded accumulate with
// saturation, and saturating subtract. Depends on cobf_pkg.
`default_nettype none

module cobf_unit (
  input  wire logic           clk_i,
  input  cobf_pkg::unit_req_t req_i,
  output cobf_pkg::sample_t   res_o
);
  import cobf_pkg::*;

  logic signed [COEF_BITS:0]   coef_s;
  logic signed [DIFF_W-1:0]    diff;
  logic signed [PROD_W-1:0]    prod_q;
  logic signed [PROD_W-1:0]    rnd;
  logic signed [RND_W-1:0]     r;
  logic signed [SUM_W-1:0]     sum;
  logic signed [SUM_W-1:0]     dif;

  assign coef_s = signed'({1'b0, req_i.coeff});
  assign diff   = DIFF_W'(req_i.z) - DIFF_W'(req_i.x);

  always_ff @(posedge clk_i) begin
    if (req_i.op == OP_MUL) begin
      prod_q <= coef_s * diff;
    end
  end

  assign rnd = prod_q + PROD_W'(signed'({1'b0, 1'b1, {(COEF_BITS-1){1'b0}}}));
  assign r   = rnd[PROD_W-1:COEF_BITS];
  assign sum = SUM_W'(req_i.x) + SUM_W'(r);
  assign dif = SUM_W'(req_i.x) - SUM_W'(req_i.z);

  always_comb begin
    case (req_i.op)
      OP_ADD:  res_o = sat_sum(sum);
      OP_SUB:  res_o = sat_sum(dif);
      default: res_o = req_i.x;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/cobf_ctrl.sv -----
// Sequencer of the cascaded one-pole band filter: stage memories, working sample, output
// register and the schedule of shared-unit operations. Depends on cobf_pkg and the interfaces.
`default_nettype none

module cobf_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  cobf_pkg::cfg_t      cfg_i,
  cobf_in_if.sink             in_i,
  cobf_out_if.source          out_o,
  output cobf_pkg::unit_req_t req_o,
  input  cobf_pkg::sample_t   res_i
);
  import cobf_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_ADD  = 5'b00100,
    ST_HSUB = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [STG_W-1:0] idx_q, idx_d;
  logic             high_q, high_d;
  sample_t          x_q, x_d;
  sample_t          zn_q, zn_d;
  sample_t          out_q, out_d;
  logic             out_valid_q, out_valid_d;
  sample_t          lo_mem_q [STAGES];
  sample_t          hi_mem_q [STAGES];
  sample_t          mem_rd;
  logic             advance;
  logic             mem_wr;
  logic [STG_W-1:0] last_idx;

  assign last_idx = cfg_i.single_stage ? STG_W'(0) : STG_W'(STAGES - 1);
  assign mem_rd   = high_q ? hi_mem_q[idx_q] : lo_mem_q[idx_q];

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_q;

  always_comb begin
    req_o.x     = x_q;
    req_o.z     = mem_rd;
    req_o.coeff = high_q ? cfg_i.high_coeff : cfg_i.low_coeff;
    req_o.op    = OP_NONE;
    unique case (state_q)
      ST_MUL:  req_o.op = OP_MUL;
      ST_ADD:  req_o.op = OP_ADD;
      ST_HSUB: begin
        req_o.op = OP_SUB;
        req_o.z  = zn_q;
      end
      default: req_o.op = OP_NONE;
    endcase
  end

  assign mem_wr  = (state_q == ST_ADD);
  assign advance = ((state_q == ST_ADD) && !high_q) || (state_q == ST_HSUB);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    high_d      = high_q;
    x_d         = x_q;
    zn_d        = zn_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          x_d     = in_i.sample_in;
          idx_d   = '0;
          high_d  = cfg_i.high_enable;
          state_d = (cfg_i.low_enable || cfg_i.high_enable) ? ST_MUL : ST_DONE;
        end
      end
      ST_MUL:  state_d = ST_ADD;
      ST_ADD: begin
        if (high_q) begin
          zn_d    = res_i;
          state_d = ST_HSUB;
        end else begin
          x_d = res_i;
        end
      end
      ST_HSUB: x_d = res_i;
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_d       = x_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (advance) begin
      if (high_q && cfg_i.low_enable) begin
        high_d  = 1'b0;
        state_d = ST_MUL;
      end else if (idx_q == last_idx) begin
        state_d = ST_DONE;
      end else begin
        idx_d   = idx_q + STG_W'(1);
        high_d  = cfg_i.high_enable;
        state_d = ST_MUL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      high_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      high_q      <= high_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    zn_q  <= zn_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < STAGES; k++) begin
        lo_mem_q[k] <= '0;
        hi_mem_q[k] <= '0;
      end
    end else if (mem_wr) begin
      if (high_q) begin
        hi_mem_q[idx_q] <= res_i;
      end else begin
        lo_mem_q[idx_q] <= res_i;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cobf_checker.sv -----
// Port-level checks for the cascaded one-pole band filter, bound to the top level.
// Depends on cobf_pkg and cascaded_one_pole_band_filter.
`default_nettype none

module cobf_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_i,
  input wire logic              out_valid_i,
  input wire logic              out_ready_i,
  input wire cobf_pkg::sample_t out_sample_i,
  input wire logic              cfg_ready_i
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_sample_i))
    else $error("Result changed or vanished while the receiver stalled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("Input still ready right after a transaction.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !out_valid_i |=> !out_valid_i)
    else $error("Result appeared one cycle after its input transaction.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_i)
    else $error("Configuration channel not ready.");

endmodule

bind cascaded_one_pole_band_filter cobf_checker u_cobf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_sample_i (out_o.sample_out),
  .cfg_ready_i  (cfg_i.ready)
);

`default_nettype wire
